>>> design/pmbt_pkg.sv
// ----------------------------------------------------------------------------
// pmbt_pkg
// Shared types and constants of the paged memory with block types: op and
// block type codes, field widths, stream packing and the queued command.
// ----------------------------------------------------------------------------
package pmbt_pkg;

	localparam int ADDRESS_BITS_DEF = 16;
	localparam int BLOCK_BITS_DEF   = 8;
	localparam int QUEUE_DEPTH      = 2;

	localparam int OP_W    = 3;
	localparam int FADDR_W = 16;
	localparam int DATA_W  = 8;
	localparam int TYPE_W  = 2;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 16;

	localparam logic [OP_W-1:0] OP_READ  = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
	localparam logic [OP_W-1:0] OP_BURN  = 3'd2;
	localparam logic [OP_W-1:0] OP_SET   = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

	localparam logic [TYPE_W-1:0] TYPE_NONE = 2'd0;
	localparam logic [TYPE_W-1:0] TYPE_RAM  = 2'd1;
	localparam logic [TYPE_W-1:0] TYPE_ROM  = 2'd2;
	localparam logic [TYPE_W-1:0] TYPE_BAD  = 2'd3;

	localparam logic [DATA_W-1:0] UNMAPPED_BYTE = 8'hFF;

	typedef enum logic [2:0] {
		K_READ,
		K_WRITE,
		K_BURN,
		K_SET,
		K_QUERY
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [FADDR_W-1:0]  address;
		logic [FADDR_W-1:0]  end_address;
		logic [DATA_W-1:0]   write_data;
		logic [TYPE_W-1:0]   new_type;
	} cmd_t;

endpackage

>>> design/paged_memory_with_block_types.sv
// ----------------------------------------------------------------------------
// paged_memory_with_block_types
// Byte memory split into blocks typed unmapped, RAM or ROM, with CPU read,
// CPU write, burn, range type set and type query over a stream interface.
// ----------------------------------------------------------------------------
// Items are queued, then executed one at a time: each is popped in ST_ISSUE
// with the type table lookup that precedes every byte access, and its result
// is registered in ST_EXEC once the output is free. A range set then walks
// its blocks in ST_WALK, writing the single type table port once a cycle.
// Reset: the type table is swept to unmapped over all of its
// 2^(ADDRESS_BITS-BLOCK_BITS) entries (256 by default), with s_axis_tready low throughout.
module paged_memory_with_block_types import pmbt_pkg::*; #(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
	parameter int BLOCK_BITS   = BLOCK_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// op, address, end_address, write_data, new_type, zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// read_data, block_type, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	cmd_t head;
	logic head_valid;
	logic pop;
	logic clearing;

	pmbt_front #(
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.clearing     (clearing),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop)
	);

	pmbt_back #(
		.ADDRESS_BITS(ADDRESS_BITS),
		.BLOCK_BITS  (BLOCK_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.clearing     (clearing),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

>>> design/pmbt_ram.sv
// ----------------------------------------------------------------------------
// pmbt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pmbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> design/pmbt_front.sv
// ----------------------------------------------------------------------------
// pmbt_front
// Input side: unpacks and classifies items, clamps set ranges to the top
// byte and folds no-effect sets into queries, then holds them in a short queue.
// ----------------------------------------------------------------------------
module pmbt_front import pmbt_pkg::*; #(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// op, address, end_address, write_data, new_type, zero pad
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	input  logic                  clearing,
	output cmd_t                  head,
	output logic                  head_valid,
	input  logic                  pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int TOP_I = (ADDRESS_BITS >= FADDR_W) ?
		(1 << FADDR_W) - 1 : (1 << ADDRESS_BITS) - 1;
	localparam logic [FADDR_W-1:0] TOP = FADDR_W'(TOP_I);

	localparam int ADDR_LSB = OP_W;
	localparam int END_LSB  = ADDR_LSB + FADDR_W;
	localparam int WD_LSB   = END_LSB + FADDR_W;
	localparam int NT_LSB   = WD_LSB + DATA_W;

	logic [OP_W-1:0]    op;
	logic [FADDR_W-1:0] last_c;
	logic               set_ok;
	logic               push;
	cmd_t               cmd_in;

	cmd_t             fifo_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_comb begin
		op                 = s_axis_tdata[OP_W-1:0];
		cmd_in.address     = s_axis_tdata[ADDR_LSB +: FADDR_W];
		cmd_in.write_data  = s_axis_tdata[WD_LSB +: DATA_W];
		cmd_in.new_type    = s_axis_tdata[NT_LSB +: TYPE_W];
		last_c             = (s_axis_tdata[END_LSB +: FADDR_W] > TOP) ?
			TOP : s_axis_tdata[END_LSB +: FADDR_W];
		cmd_in.end_address = last_c;
		set_ok = (s_axis_tdata[END_LSB +: FADDR_W] >= cmd_in.address) &&
			(cmd_in.new_type != TYPE_BAD) && (cmd_in.address <= last_c);
		unique case (op)
			OP_READ:  cmd_in.kind = K_READ;
			OP_WRITE: cmd_in.kind = K_WRITE;
			OP_BURN:  cmd_in.kind = K_BURN;
			OP_SET:   cmd_in.kind = set_ok ? K_SET : K_QUERY;
			default:  cmd_in.kind = K_QUERY;
		endcase
	end

	assign s_axis_tready = (count_q != CNT_W'(QUEUE_DEPTH)) && !clearing;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign head_valid    = (count_q != '0);
	assign head          = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

>>> design/pmbt_back.sv
// ----------------------------------------------------------------------------
// pmbt_back
// Execution side: clears the type table after reset, looks up block types,
// reads or writes the byte store, walks set ranges and holds the result.
// ----------------------------------------------------------------------------
module pmbt_back import pmbt_pkg::*; #(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
	parameter int BLOCK_BITS   = BLOCK_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   head,
	input  logic                   head_valid,
	output logic                   pop,
	output logic                   clearing,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// read_data, block_type, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int NBW = ADDRESS_BITS - BLOCK_BITS;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_ISSUE,
		ST_EXEC,
		ST_WALK
	} state_t;

	state_t            state_q;
	logic [NBW-1:0]    cnt_q;
	logic [NBW-1:0]    last_q;
	cmd_t              cmd_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] read_data_q;
	logic [TYPE_W-1:0] block_type_q;

	logic [ADDRESS_BITS-1:0] head_addr;
	logic [ADDRESS_BITS-1:0] cmd_addr;
	logic [ADDRESS_BITS-1:0] cmd_last;
	logic [DATA_W-1:0]       dmem_rd;
	logic [TYPE_W-1:0]       tmem_rd;
	logic                    go;
	logic                    dmem_we;
	logic                    tmem_we;
	logic [DATA_W-1:0]       res_data;
	logic [TYPE_W-1:0]       res_type;

	assign head_addr = ADDRESS_BITS'(head.address);
	assign cmd_addr  = ADDRESS_BITS'(cmd_q.address);
	assign cmd_last  = ADDRESS_BITS'(cmd_q.end_address);
	assign pop       = (state_q == ST_ISSUE) && head_valid;
	assign clearing  = (state_q == ST_CLEAR);
	assign go        = !out_valid_q || m_axis_tready;
	assign tmem_we   = (state_q == ST_CLEAR) || (state_q == ST_WALK);

	always_comb begin
		res_data = '0;
		res_type = tmem_rd;
		dmem_we  = 1'b0;
		case (cmd_q.kind)
			K_READ:  res_data = (tmem_rd != TYPE_NONE) ? dmem_rd : UNMAPPED_BYTE;
			K_WRITE: dmem_we  = (tmem_rd == TYPE_RAM);
			K_BURN:  dmem_we  = (tmem_rd != TYPE_NONE);
			K_SET:   res_type = cmd_q.new_type;
			default: res_type = tmem_rd;
		endcase
		dmem_we = dmem_we && (state_q == ST_EXEC) && go;
	end

	pmbt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(1 << ADDRESS_BITS)
	) u_data_ram (
		.clk    (clk),
		.wr_en  (dmem_we),
		.wr_addr(cmd_addr),
		.wr_data(cmd_q.write_data),
		.rd_en  (pop),
		.rd_addr(head_addr),
		.rd_data(dmem_rd)
	);

	pmbt_ram #(
		.WIDTH(TYPE_W),
		.DEPTH(1 << NBW)
	) u_type_ram (
		.clk    (clk),
		.wr_en  (tmem_we),
		.wr_addr(cnt_q),
		.wr_data((state_q == ST_CLEAR) ? TYPE_NONE : cmd_q.new_type),
		.rd_en  (pop),
		.rd_addr(head_addr[ADDRESS_BITS-1:BLOCK_BITS]),
		.rd_data(tmem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			last_q       <= '0;
			cmd_q        <= '0;
			out_valid_q  <= 1'b0;
			read_data_q  <= '0;
			block_type_q <= '0;
		end else begin
			if (state_q == ST_EXEC && go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + NBW'(1);
					if (cnt_q == {NBW{1'b1}}) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (head_valid) begin
						cmd_q   <= head;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go) begin
						read_data_q  <= res_data;
						block_type_q <= res_type;
						if (cmd_q.kind == K_SET) begin
							cnt_q   <= cmd_addr[ADDRESS_BITS-1:BLOCK_BITS];
							last_q  <= cmd_last[ADDRESS_BITS-1:BLOCK_BITS];
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_WALK: begin
					cnt_q <= cnt_q + NBW'(1);
					if (cnt_q == last_q) begin
						state_q <= ST_ISSUE;
					end
				end
				default: state_q <= ST_ISSUE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - DATA_W - TYPE_W){1'b0}}, block_type_q, read_data_q};

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
		else $error("type table clearing restarted");

	a_issue_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE && head_valid) |=> (state_q == ST_EXEC))
		else $error("popped item not executed");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (cnt_q <= last_q))
		else $error("range walk past last block");

	a_exec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && out_valid_q && !m_axis_tready) |=> (state_q == ST_EXEC))
		else $error("result overwritten while output stalled");

endmodule
